// ===== rtl/ltr_pkg.sv =====
// shared types and codes for the lossy trace ring
package ltr_pkg;

    localparam int CFG_IDX_W = 2;

    localparam logic [1:0] ACT_PUSH  = 2'd0;
    localparam logic [1:0] ACT_DRAIN = 2'd1;
    localparam logic [1:0] ACT_ARM   = 2'd2;
    localparam logic [1:0] ACT_IDLE  = 2'd3;

    localparam logic [CFG_IDX_W-1:0] CFG_BEGIN_CODE = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_END_CODE   = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_OVF_CODE   = 2'd2;

    localparam logic [7:0] RST_BEGIN_CODE = 8'd1;
    localparam logic [7:0] RST_END_CODE   = 8'd2;
    localparam logic [7:0] RST_OVF_CODE   = 8'd3;

    localparam logic [7:0] DROP_MAX = 8'hff;

    typedef struct packed {
        logic [1:0]  action;
        logic [7:0]  frame_type;
        logic [7:0]  frame_flags;
        logic [15:0] frame_time;
        logic [7:0]  frame_arg_a;
        logic [7:0]  frame_arg_b;
        logic [15:0] now_time;
        logic [7:0]  programmer_state;
    } ltr_in_t;

    typedef struct packed {
        logic        accepted;
        logic        drained_valid;
        logic [7:0]  out_type;
        logic [7:0]  out_flags;
        logic [15:0] out_time;
        logic [7:0]  out_arg_a;
        logic [7:0]  out_arg_b;
        logic [7:0]  out_prog_state;
        logic [7:0]  fill_count;
        logic [15:0] total_writes;
        logic        overflow_seen;
        logic        capture_mode;
    } ltr_out_t;

    typedef struct packed {
        logic [7:0]  ftype;
        logic [7:0]  flags;
        logic [15:0] stamp;
        logic [7:0]  arg_a;
        logic [7:0]  arg_b;
    } ltr_frame_t;

    // classified command handed from the front to the back
    typedef struct packed {
        logic [1:0]  action;
        logic        is_meta;
        ltr_frame_t  frame;
        logic [15:0] now_time;
        logic [7:0]  pgm_byte;
        logic [7:0]  ovf_type;
    } ltr_cmd_t;

    // queue head as seen by the back
    typedef struct packed {
        logic     valid;
        ltr_cmd_t cmd;
    } ltr_head_t;

endpackage

// ===== rtl/ltr_front.sv =====
// front end: type code registers and classification of incoming items
module ltr_front
    import ltr_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 cfg_valid,
    output logic                 cfg_ready,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [7:0]           cfg_data,
    input  ltr_in_t              req,
    output ltr_cmd_t             cmd
);

    logic [7:0] begin_code_reg;
    logic [7:0] end_code_reg;
    logic [7:0] ovf_code_reg;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            begin_code_reg <= RST_BEGIN_CODE;
            end_code_reg   <= RST_END_CODE;
            ovf_code_reg   <= RST_OVF_CODE;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                CFG_BEGIN_CODE: begin_code_reg <= cfg_data;
                CFG_END_CODE:   end_code_reg   <= cfg_data;
                CFG_OVF_CODE:   ovf_code_reg   <= cfg_data;
                default:        ;
            endcase
        end
    end

    always_comb
    begin
        cmd.action       = req.action;
        // begin and end frames never release a pending marker
        cmd.is_meta      = (req.frame_type == begin_code_reg) ||
                           (req.frame_type == end_code_reg);
        cmd.frame.ftype  = req.frame_type;
        cmd.frame.flags  = req.frame_flags;
        cmd.frame.stamp  = req.frame_time;
        cmd.frame.arg_a  = req.frame_arg_a;
        cmd.frame.arg_b  = req.frame_arg_b;
        cmd.now_time     = req.now_time;
        cmd.pgm_byte     = req.programmer_state;
        cmd.ovf_type     = ovf_code_reg;
    end

endmodule

// ===== rtl/ltr_queue.sv =====
// two-entry command queue between front and back
module ltr_queue
    import ltr_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      push,
    input  ltr_cmd_t  push_cmd,
    output logic      full,
    output ltr_head_t head,
    input  logic      pop
);

    ltr_cmd_t   entry_reg [2];
    logic       wr_ptr_reg;
    logic       rd_ptr_reg;
    logic [1:0] count_reg;

    assign full       = (count_reg == 2'd2);
    assign head.valid = (count_reg != 2'd0);
    assign head.cmd   = entry_reg[rd_ptr_reg];

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_ptr_reg] <= push_cmd;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= ~wr_ptr_reg;
            end
            if (pop)
            begin
                rd_ptr_reg <= ~rd_ptr_reg;
            end
            if (push && !pop)
            begin
                count_reg <= count_reg + 2'd1;
            end
            else if (pop && !push)
            begin
                count_reg <= count_reg - 2'd1;
            end
        end
    end

endmodule

// ===== rtl/ltr_back.sv =====
// back end: ring storage, counters, marker insertion and result register
module ltr_back
    import ltr_pkg::*;
#(
    parameter int SLOTS = 32
)
(
    input  logic      clk,
    input  logic      rst_n,
    input  ltr_head_t head,
    output logic      pop,
    output logic      rsp_valid,
    input  logic      rsp_stall,
    output ltr_out_t  rsp
);

    localparam int SLOT_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;
    localparam int FILL_W = $clog2(SLOTS + 1);
    localparam logic [SLOT_W-1:0] LAST_SLOT = SLOT_W'(SLOTS - 1);
    localparam logic [FILL_W-1:0] FULL_FILL = FILL_W'(SLOTS);

    typedef enum logic [1:0] {
        S_IDLE,
        S_PUSH2,
        S_READ
    } state_t;

    state_t state_reg;
    state_t state_next;

    logic [SLOT_W-1:0] wp_reg, wp_next;
    logic [SLOT_W-1:0] rp_reg, rp_next;
    logic [FILL_W-1:0] fill_reg, fill_next;
    logic [15:0]       wcnt_reg, wcnt_next;
    logic [7:0]        drop_reg, drop_next;
    logic              sticky_reg, sticky_next;
    logic              pend_reg, pend_next;
    logic              armed_reg, armed_next;

    ltr_frame_t        mem [SLOTS];
    ltr_frame_t        rd_data_reg;
    logic              wr_en;
    ltr_frame_t        wr_data;
    logic              rd_en;

    logic              rsp_valid_reg;
    ltr_out_t          rsp_reg;
    ltr_out_t          out_next;
    logic              load_out;
    logic              out_free;

    logic              full;
    logic [SLOT_W-1:0] wp_inc;
    logic [SLOT_W-1:0] rp_inc;
    ltr_frame_t        marker;
    ltr_cmd_t          cmd;

    assign cmd      = head.cmd;
    assign out_free = !rsp_valid_reg || !rsp_stall;
    assign full     = (fill_reg == FULL_FILL);
    assign wp_inc   = (wp_reg == LAST_SLOT) ? '0 : wp_reg + 1'b1;
    assign rp_inc   = (rp_reg == LAST_SLOT) ? '0 : rp_reg + 1'b1;

    always_comb
    begin
        marker.ftype = cmd.ovf_type;
        marker.flags = 8'h00;
        marker.stamp = cmd.now_time;
        marker.arg_a = drop_reg;
        marker.arg_b = 8'h00;
    end

    always_comb
    begin
        state_next  = state_reg;
        wp_next     = wp_reg;
        rp_next     = rp_reg;
        fill_next   = fill_reg;
        wcnt_next   = wcnt_reg;
        drop_next   = drop_reg;
        sticky_next = sticky_reg;
        pend_next   = pend_reg;
        armed_next  = armed_reg;
        wr_en       = 1'b0;
        wr_data     = cmd.frame;
        rd_en       = 1'b0;
        pop         = 1'b0;
        load_out    = 1'b0;
        out_next    = '0;

        case (state_reg)
            S_IDLE:
            begin
                if (head.valid && out_free)
                begin
                    case (cmd.action)
                        ACT_PUSH:
                        begin
                            if (pend_reg && !cmd.is_meta && !full)
                            begin
                                // marker goes in first, the frame in S_PUSH2 once the result register is free
                                wr_en       = 1'b1;
                                wr_data     = marker;
                                wp_next     = wp_inc;
                                wcnt_next   = wcnt_reg + 16'd1;
                                fill_next   = fill_reg + 1'b1;
                                drop_next   = '0;
                                pend_next   = 1'b0;
                                state_next  = S_PUSH2;
                            end
                            else
                            begin
                                wr_en     = 1'b1;
                                wp_next   = wp_inc;
                                wcnt_next = wcnt_reg + 16'd1;
                                if (full)
                                begin
                                    rp_next     = rp_inc;
                                    drop_next   = (drop_reg == DROP_MAX) ? drop_reg
                                                                         : drop_reg + 8'd1;
                                    sticky_next = 1'b1;
                                    pend_next   = 1'b1;
                                end
                                else
                                begin
                                    fill_next = fill_reg + 1'b1;
                                end
                                out_next.accepted = 1'b1;
                                pop      = 1'b1;
                                load_out = 1'b1;
                            end
                        end
                        ACT_DRAIN:
                        begin
                            if (fill_reg == '0)
                            begin
                                if (pend_reg)
                                begin
                                    out_next.drained_valid  = 1'b1;
                                    out_next.out_type       = marker.ftype;
                                    out_next.out_time       = marker.stamp;
                                    out_next.out_arg_a      = marker.arg_a;
                                    out_next.out_prog_state = cmd.pgm_byte;
                                    drop_next = '0;
                                    pend_next = 1'b0;
                                end
                                pop      = 1'b1;
                                load_out = 1'b1;
                            end
                            else
                            begin
                                rd_en      = 1'b1;
                                rp_next    = rp_inc;
                                fill_next  = fill_reg - 1'b1;
                                state_next = S_READ;
                            end
                        end
                        ACT_ARM:
                        begin
                            wp_next     = '0;
                            rp_next     = '0;
                            fill_next   = '0;
                            wcnt_next   = '0;
                            drop_next   = '0;
                            sticky_next = 1'b0;
                            pend_next   = 1'b0;
                            armed_next  = 1'b1;
                            pop         = 1'b1;
                            load_out    = 1'b1;
                        end
                        ACT_IDLE:
                        begin
                            armed_next = 1'b0;
                            pop        = 1'b1;
                            load_out   = 1'b1;
                        end
                        default:
                        begin
                            pop      = 1'b1;
                            load_out = 1'b1;
                        end
                    endcase
                end
            end
            S_PUSH2:
            begin
                if (out_free)
                begin
                    // the marker may have taken the last free slot
                    wr_en     = 1'b1;
                    wp_next   = wp_inc;
                    wcnt_next = wcnt_reg + 16'd1;
                    if (full)
                    begin
                        rp_next     = rp_inc;
                        drop_next   = (drop_reg == DROP_MAX) ? drop_reg : drop_reg + 8'd1;
                        sticky_next = 1'b1;
                        pend_next   = 1'b1;
                    end
                    else
                    begin
                        fill_next = fill_reg + 1'b1;
                    end
                    out_next.accepted = 1'b1;
                    pop        = 1'b1;
                    load_out   = 1'b1;
                    state_next = S_IDLE;
                end
            end
            S_READ:
            begin
                if (out_free)
                begin
                    out_next.drained_valid  = 1'b1;
                    out_next.out_type       = rd_data_reg.ftype;
                    out_next.out_flags      = rd_data_reg.flags;
                    out_next.out_time       = rd_data_reg.stamp;
                    out_next.out_arg_a      = rd_data_reg.arg_a;
                    out_next.out_arg_b      = rd_data_reg.arg_b;
                    out_next.out_prog_state = cmd.pgm_byte;
                    pop        = 1'b1;
                    load_out   = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase

        out_next.fill_count    = 8'(fill_next);
        out_next.total_writes  = wcnt_next;
        out_next.overflow_seen = sticky_next;
        out_next.capture_mode  = armed_next;
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wp_reg] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[rp_reg];
        end
        if (load_out)
        begin
            rsp_reg <= out_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            wp_reg        <= '0;
            rp_reg        <= '0;
            fill_reg      <= '0;
            wcnt_reg      <= '0;
            drop_reg      <= '0;
            sticky_reg    <= 1'b0;
            pend_reg      <= 1'b0;
            armed_reg     <= 1'b0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            wp_reg     <= wp_next;
            rp_reg     <= rp_next;
            fill_reg   <= fill_next;
            wcnt_reg   <= wcnt_next;
            drop_reg   <= drop_next;
            sticky_reg <= sticky_next;
            pend_reg   <= pend_next;
            armed_reg  <= armed_next;
            if (load_out)
            begin
                rsp_valid_reg <= 1'b1;
            end
            else if (!rsp_stall)
            begin
                rsp_valid_reg <= 1'b0;
            end
        end
    end

    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

endmodule

// ===== rtl/lossy_trace_ring_with_loss_marker.sv =====
// top level of the lossy trace ring with loss marker
// usage:
// - req carries one command (push, drain, arm, idle) per transfer, taken at a
//   rising edge with req_valid high and req_stall low; rsp returns exactly one
//   result per command in order, under the same valid/stall rule
// - cfg_index/cfg_data write the begin, end and overflow type codes; cfg_ready
//   is always high, and writes belong in periods with no command in flight
// - a command lands in a two-entry queue, so req_stall rises only when the
//   queue is full; the ring logic behind it works on one command at a time
// - a plain push, arm, idle or drain of an empty ring is handled in S_IDLE;
//   a push that first inserts the loss marker goes on to S_PUSH2 (two writes
//   on the single store write port), and a drain that reads the store goes on
//   to S_READ (registered read of the frame memory)
// - sustained rate is one command per cycle while the result is not stalled,
//   but marker pushes and stored-frame drains also pass S_PUSH2 or S_READ
// - a stalled result holds in the output register; the back waits and the
//   queue fills, after which req_stall is raised
// - reset empties the ring, clears all counters and flags, enters idle mode and
//   restores the default type codes; the frame memory itself is not cleared
module lossy_trace_ring_with_loss_marker
    import ltr_pkg::*;
#(
    parameter int SLOTS = 32
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 cfg_valid,
    output logic                 cfg_ready,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [7:0]           cfg_data,
    input  logic                 req_valid,
    output logic                 req_stall,
    input  ltr_in_t              req,
    output logic                 rsp_valid,
    input  logic                 rsp_stall,
    output ltr_out_t             rsp
);

    ltr_cmd_t  cmd;
    ltr_head_t head;
    logic      q_full;
    logic      q_pop;

    assign req_stall = q_full;

    ltr_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .req       (req),
        .cmd       (cmd)
    );

    ltr_queue u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (req_valid && !req_stall),
        .push_cmd (cmd),
        .full     (q_full),
        .head     (head),
        .pop      (q_pop)
    );

    ltr_back #(
        .SLOTS (SLOTS)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .head      (head),
        .pop       (q_pop),
        .rsp_valid (rsp_valid),
        .rsp_stall (rsp_stall),
        .rsp       (rsp)
    );

endmodule
